// ===== hw/rtl/bkr_pkg.sv =====
// ----------------------------------------------------------------------------
// bkr_pkg
// Shared types, constants and helper functions of the banker's resource
// manager.
// ----------------------------------------------------------------------------
package bkr_pkg;

    localparam int PROCESSES  = 8;
    localparam int RESOURCES  = 4;
    localparam int COUNT_BITS = 8;
    localparam int FREE_BITS  = 12;

    localparam int CMD_BITS  = 3;
    localparam int PROC_BITS = 3;
    localparam int RES_BITS  = 2;
    localparam int ROW_BITS  = RESOURCES * COUNT_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SET_TOTAL = 3'd0,
        CMD_SET_CLAIM = 3'd1,
        CMD_SET_HELD  = 3'd2,
        CMD_REQUEST   = 3'd3,
        CMD_RELEASE   = 3'd4,
        CMD_CHECK     = 3'd5
    } cmd_t;

    typedef logic [COUNT_BITS-1:0]               count_t;
    typedef logic signed [FREE_BITS-1:0]         unit_t;
    typedef unit_t                               unit_vec_t [RESOURCES];
    typedef logic [RESOURCES-1:0][COUNT_BITS-1:0] row_t;

    function automatic unit_t ext_count(count_t c);
        return unit_t'({{(FREE_BITS-COUNT_BITS){1'b0}}, c});
    endfunction

    // True when need = claim - held is at most work for every resource.
    function automatic logic row_fits(row_t claim, row_t held, unit_vec_t work);
        logic  ok;
        unit_t need;
        ok = 1'b1;
        for (int i = 0; i < RESOURCES; i++)
        begin
            need = ext_count(claim[i]) - ext_count(held[i]);
            if (need > work[i])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== hw/rtl/bkr_if.sv =====
// ----------------------------------------------------------------------------
// bkr_cmd_if / bkr_rsp_if
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface bkr_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [bkr_pkg::CMD_BITS-1:0]   command;
    logic [bkr_pkg::PROC_BITS-1:0]  process;
    logic [bkr_pkg::RES_BITS-1:0]   resource;
    logic [bkr_pkg::COUNT_BITS-1:0] amount;

    modport source (output valid, command, process, resource, amount, input ready);
    modport sink   (input valid, command, process, resource, amount, output ready);
endinterface

interface bkr_rsp_if;
    logic valid;
    logic ready;
    logic granted;
    logic safe;

    modport source (output valid, granted, safe, input ready);
    modport sink   (input valid, granted, safe, output ready);
endinterface

// ===== hw/rtl/bkr_ram.sv =====
// ----------------------------------------------------------------------------
// bkr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bankers_resource_manager_unit.sv =====
// ----------------------------------------------------------------------------
// bankers_resource_manager_unit
// Banker's algorithm resource manager with a row-wise safety search.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd, one response per command leaves on rsp.
// Claim and held amounts live in two RAMs with one row per process, all
// resources side by side; totals and free counts are registers.
// A load, request or release reads the process row in the transfer cycle and
// writes a changed row back in the next one; rsp.valid rises after the EXEC
// and RESP states, with cmd.ready back high in the same cycle. A safety check
// starts the work vector at the free counts and scans one process row per
// cycle through the RAM read port, restarting at process 0 after each mark;
// when the scan ends, the result passes through RESP into the output register.
// One command is in progress at a time; a new one is taken as soon as the
// previous result sits in the output register.
// Reset clears totals and free counts, then a clearing pass through S_CLEAR
// zeroes every claim and held row; cmd.ready stays low meanwhile.
// A stalled receiver holds the response; the unit then waits with the next
// result until the output register is free.
// ----------------------------------------------------------------------------
module bankers_resource_manager_unit (
    input  logic      clk,
    input  logic      rst_n,
    bkr_cmd_if.sink   cmd,
    bkr_rsp_if.source rsp
);
    import bkr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [CMD_BITS-1:0]   cmd_reg;
    logic [PROC_BITS-1:0]  proc_reg;
    logic [RES_BITS-1:0]   res_reg;
    count_t                amt_reg;
    count_t                total_reg [RESOURCES];
    unit_t                 free_reg  [RESOURCES];
    unit_vec_t             work_reg;
    logic [PROCESSES-1:0]  marks_reg;
    logic [PROC_BITS-1:0]  ptr_reg;
    logic [PROC_BITS-1:0]  cnt_reg;
    logic                  granted_reg;
    logic                  safe_reg;
    logic                  res_granted_reg;
    logic                  res_safe_reg;
    logic                  out_valid_reg;

    logic [PROC_BITS-1:0]  raddr;
    row_t                  claim_rd;
    row_t                  held_rd;
    row_t                  claim_wd;
    row_t                  held_wd;
    logic                  claim_we;
    logic                  held_we;
    logic                  fit;
    logic                  exec_ok;
    count_t                held_cur;
    count_t                held_new;
    unit_t                 free_new;
    logic [COUNT_BITS:0]   held_sum;

    assign cmd.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.granted   = granted_reg;
    assign rsp.safe      = safe_reg;

    assign fit = !marks_reg[ptr_reg] && row_fits(claim_rd, held_rd, work_reg);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
                raddr = (cmd_t'(cmd.command) == CMD_CHECK) ? '0 : cmd.process;
            S_SCAN:
                raddr = fit ? '0 : PROC_BITS'(ptr_reg + 1'b1);
            default:
                raddr = ptr_reg;
        endcase
    end

    // Read-modify-write of one lane of the process row.
    always_comb
    begin
        held_cur = held_rd[res_reg];
        held_sum = {1'b0, held_cur} + {1'b0, amt_reg};
        held_new = held_cur;
        free_new = free_reg[res_reg];
        exec_ok  = 1'b0;
        claim_wd = claim_rd;
        held_wd  = held_rd;
        claim_we = 1'b0;
        held_we  = 1'b0;
        unique case (cmd_t'(cmd_reg))
            CMD_SET_TOTAL:
            begin
                free_new = free_reg[res_reg] + ext_count(amt_reg)
                           - ext_count(total_reg[res_reg]);
                exec_ok  = 1'b1;
            end
            CMD_SET_CLAIM:
            begin
                claim_wd[res_reg] = amt_reg;
                claim_we = 1'b1;
                exec_ok  = 1'b1;
            end
            CMD_SET_HELD:
            begin
                held_new = amt_reg;
                free_new = free_reg[res_reg] + ext_count(held_cur) - ext_count(amt_reg);
                exec_ok  = 1'b1;
            end
            CMD_REQUEST:
            begin
                if (free_reg[res_reg] >= ext_count(amt_reg) && !held_sum[COUNT_BITS])
                begin
                    held_new = held_sum[COUNT_BITS-1:0];
                    free_new = free_reg[res_reg] - ext_count(amt_reg);
                    exec_ok  = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                if (held_cur >= amt_reg)
                begin
                    held_new = held_cur - amt_reg;
                    free_new = free_reg[res_reg] + ext_count(amt_reg);
                    exec_ok  = 1'b1;
                end
            end
            default:
            begin
                exec_ok = 1'b0;
            end
        endcase
        held_wd[res_reg] = held_new;
        if (state_reg == S_EXEC && exec_ok && cmd_t'(cmd_reg) != CMD_SET_CLAIM
            && cmd_t'(cmd_reg) != CMD_SET_TOTAL)
        begin
            held_we = 1'b1;
        end
        if (state_reg != S_EXEC)
        begin
            claim_we = 1'b0;
        end
        // The clearing pass after reset writes zero rows at proc_reg.
        if (state_reg == S_CLEAR)
        begin
            claim_wd = '0;
            held_wd  = '0;
            claim_we = 1'b1;
            held_we  = 1'b1;
        end
    end

    bkr_ram #(.WIDTH(ROW_BITS), .DEPTH(PROCESSES)) u_claim_ram (
        .clk   (clk),
        .we    (claim_we),
        .waddr (proc_reg),
        .wdata (claim_wd),
        .raddr (raddr),
        .rdata (claim_rd)
    );

    bkr_ram #(.WIDTH(ROW_BITS), .DEPTH(PROCESSES)) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (proc_reg),
        .wdata (held_wd),
        .raddr (raddr),
        .rdata (held_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            out_valid_reg   <= 1'b0;
            granted_reg     <= 1'b0;
            safe_reg        <= 1'b0;
            res_granted_reg <= 1'b0;
            res_safe_reg    <= 1'b0;
            marks_reg       <= '0;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            cmd_reg         <= '0;
            proc_reg        <= '0;
            res_reg         <= '0;
            amt_reg         <= '0;
            for (int i = 0; i < RESOURCES; i++)
            begin
                total_reg[i] <= '0;
                free_reg[i]  <= '0;
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    proc_reg <= PROC_BITS'(proc_reg + 1'b1);
                    if (proc_reg == PROC_BITS'(PROCESSES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg  <= cmd.command;
                        proc_reg <= cmd.process;
                        res_reg  <= cmd.resource;
                        amt_reg  <= cmd.amount;
                        if (cmd_t'(cmd.command) == CMD_CHECK)
                        begin
                            for (int i = 0; i < RESOURCES; i++)
                            begin
                                work_reg[i] <= free_reg[i];
                            end
                            marks_reg <= '0;
                            ptr_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    if (exec_ok)
                    begin
                        free_reg[res_reg] <= free_new;
                        if (cmd_t'(cmd_reg) == CMD_SET_TOTAL)
                        begin
                            total_reg[res_reg] <= amt_reg;
                        end
                    end
                    res_granted_reg <= exec_ok;
                    res_safe_reg    <= 1'b0;
                    state_reg       <= S_RESP;
                end
                S_SCAN:
                begin
                    if (fit)
                    begin
                        marks_reg[ptr_reg] <= 1'b1;
                        for (int i = 0; i < RESOURCES; i++)
                        begin
                            work_reg[i] <= work_reg[i] + ext_count(held_rd[i]);
                        end
                        ptr_reg <= '0;
                        cnt_reg <= PROC_BITS'(cnt_reg + 1'b1);
                        if (cnt_reg == PROC_BITS'(PROCESSES - 1))
                        begin
                            res_granted_reg <= 1'b0;
                            res_safe_reg    <= 1'b1;
                            state_reg       <= S_RESP;
                        end
                    end
                    else if (ptr_reg == PROC_BITS'(PROCESSES - 1))
                    begin
                        res_granted_reg <= 1'b0;
                        res_safe_reg    <= 1'b0;
                        state_reg       <= S_RESP;
                    end
                    else
                    begin
                        ptr_reg <= PROC_BITS'(ptr_reg + 1'b1);
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        granted_reg   <= res_granted_reg;
                        safe_reg      <= res_safe_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_bankers_resource_manager_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bankers_resource_manager_unit
// Drives load, request, release and safety-check commands into the banker's
// resource manager, predicts every response from its own copy of the counts
// and compares granted and safe on each response transfer.
// ----------------------------------------------------------------------------
module tb_bankers_resource_manager_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bkr_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_B = 3'd7;
    localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic granted;
        logic safe;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    bkr_cmd_if cmd ();
    bkr_rsp_if rsp ();

    bankers_resource_manager_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // Own copy of the unit's bookkeeping.
    int total_cnt [RESOURCES];
    int free_cnt  [RESOURCES];
    int claim_cnt [PROCESSES][RESOURCES];
    int held_cnt  [PROCESSES][RESOURCES];

    answer_t answer_q [$];
    int      mismatches;
    int      idle_cycles;
    bit      no_gaps;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic banker_safe();
        int  work [RESOURCES];
        bit  done [PROCESSES];
        int  marked;
        int  pick;
        bit  fits;
        for (int r = 0; r < RESOURCES; r++)
        begin
            work[r] = free_cnt[r];
        end
        for (int p = 0; p < PROCESSES; p++)
        begin
            done[p] = 1'b0;
        end
        marked = 0;
        forever
        begin
            pick = -1;
            for (int p = 0; p < PROCESSES && pick < 0; p++)
            begin
                fits = !done[p];
                for (int r = 0; r < RESOURCES; r++)
                begin
                    if (claim_cnt[p][r] - held_cnt[p][r] > work[r])
                    begin
                        fits = 1'b0;
                    end
                end
                if (fits)
                begin
                    pick = p;
                end
            end
            if (pick < 0)
            begin
                return 1'b0;
            end
            done[pick] = 1'b1;
            for (int r = 0; r < RESOURCES; r++)
            begin
                work[r] += held_cnt[pick][r];
            end
            marked++;
            if (marked == PROCESSES)
            begin
                return 1'b1;
            end
        end
    endfunction

    function automatic answer_t apply_command(logic [2:0] c, int p, int r, int amt);
        answer_t a;
        a = '0;
        case (c)
            CMD_SET_TOTAL:
            begin
                free_cnt[r] += amt - total_cnt[r];
                total_cnt[r] = amt;
                a.granted = 1'b1;
            end
            CMD_SET_CLAIM:
            begin
                claim_cnt[p][r] = amt;
                a.granted = 1'b1;
            end
            CMD_SET_HELD:
            begin
                free_cnt[r] += held_cnt[p][r] - amt;
                held_cnt[p][r] = amt;
                a.granted = 1'b1;
            end
            CMD_REQUEST:
            begin
                if (free_cnt[r] >= amt && held_cnt[p][r] + amt <= COUNT_TOP)
                begin
                    held_cnt[p][r] += amt;
                    free_cnt[r] -= amt;
                    a.granted = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                if (held_cnt[p][r] >= amt)
                begin
                    held_cnt[p][r] -= amt;
                    free_cnt[r] += amt;
                    a.granted = 1'b1;
                end
            end
            CMD_CHECK:
            begin
                a.safe = banker_safe();
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    // Sends one command; the gap before it is drawn per item. Valid is only
    // lowered when a gap follows, so back-to-back transfers keep it high.
    task automatic send_cmd(logic [2:0] c, int p, int r, int amt);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.command  <= c;
        cmd.process  <= p[PROC_BITS-1:0];
        cmd.resource <= r[RES_BITS-1:0];
        cmd.amount   <= amt[COUNT_BITS-1:0];
        @(posedge clk);
        while (!cmd.ready)
        begin
            @(posedge clk);
        end
        answer_q.push_back(apply_command(c, p, r, amt));
    endtask

    task automatic drain();
        @(posedge clk);
        cmd.valid <= 1'b0;
        while (answer_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
    endtask

    // Response side: random stall per item, then check on the transfer.
    initial
    begin
        answer_t want;
        int stall;
        mismatches = 0;
        rsp.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
            begin
                @(posedge clk);
            end
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected response: granted %0b safe %0b",
                             rsp.granted, rsp.safe);
                end
            end
            else
            begin
                want = answer_q.pop_front();
                if (rsp.granted !== want.granted || rsp.safe !== want.safe)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("response mismatch: granted exp %0b got %0b, safe exp %0b got %0b",
                                 want.granted, rsp.granted, want.safe, rsp.safe);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Loads every claim and held entry with zero through the command channel.
    task automatic test_clear_tables();
        for (int p = 0; p < PROCESSES; p++)
        begin
            for (int r = 0; r < RESOURCES; r++)
            begin
                send_cmd(CMD_SET_CLAIM, p, r, 0);
                send_cmd(CMD_SET_HELD, p, r, 0);
            end
        end
        drain();
    endtask

    task automatic test_directed();
        send_cmd(CMD_CHECK, 0, 0, 0);
        send_cmd(CMD_SET_TOTAL, 0, 0, 255);
        send_cmd(CMD_SET_TOTAL, 0, 3, 0);
        send_cmd(CMD_REQUEST, 7, 0, 255);
        send_cmd(CMD_REQUEST, 7, 0, 1);
        send_cmd(CMD_REQUEST, 0, 3, 1);
        send_cmd(CMD_REQUEST, 0, 3, 0);
        send_cmd(CMD_RELEASE, 7, 0, 0);
        send_cmd(CMD_RELEASE, 7, 1, 1);
        send_cmd(CMD_SET_CLAIM, 7, 0, 255);
        send_cmd(CMD_SET_CLAIM, 3, 2, 200);
        send_cmd(CMD_CHECK, 5, 2, 170);
        // Held above the total drives the free count negative.
        send_cmd(CMD_SET_HELD, 2, 3, 255);
        send_cmd(CMD_CHECK, 0, 0, 0);
        send_cmd(CMD_RELEASE, 2, 3, 255);
        send_cmd(CMD_RELEASE, 7, 0, 128);
        send_cmd(CMD_SET_TOTAL, 0, 2, 200);
        send_cmd(CMD_CHECK, 0, 0, 0);
        send_cmd(CMD_UNUSED_A, 7, 3, 255);
        send_cmd(CMD_UNUSED_B, 0, 0, 0);
        send_cmd(CMD_SET_CLAIM, 7, 0, 0);
        send_cmd(CMD_SET_CLAIM, 3, 2, 0);
        send_cmd(CMD_CHECK, 7, 3, 255);
        drain();
    endtask

    task automatic test_random();
        int sent;
        int kind;
        logic [2:0] c;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                // Allocation scenario: totals, a few claims, then traffic.
                for (int r = 0; r < RESOURCES; r++)
                begin
                    send_cmd(CMD_SET_TOTAL, 0, r,
                             ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 40));
                end
                repeat ($urandom_range(2, 10))
                begin
                    send_cmd(CMD_SET_CLAIM, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 20));
                end
                repeat ($urandom_range(10, 30))
                begin
                    kind = $urandom_range(0, 9);
                    c = (kind < 4) ? CMD_REQUEST : (kind < 7) ? CMD_RELEASE : CMD_CHECK;
                    send_cmd(c, $urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 12));
                    sent++;
                end
                sent += RESOURCES + 6;
            end
            else
            begin
                repeat ($urandom_range(5, 15))
                begin
                    send_cmd(CMD_BITS'($urandom_range(0, 7)), $urandom_range(0, 7),
                             $urandom_range(0, 3), $urandom_range(0, 255));
                    sent++;
                end
                // Bring held amounts back to small values now and then.
                if ($urandom_range(0, 1) == 0)
                begin
                    repeat (4)
                    begin
                        send_cmd(CMD_SET_HELD, $urandom_range(0, 7), $urandom_range(0, 3),
                                 $urandom_range(0, 3));
                        sent++;
                    end
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
            end
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        cmd.valid    = 1'b0;
        cmd.command  = '0;
        cmd.process  = '0;
        cmd.resource = '0;
        cmd.amount   = '0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            total_cnt[r] = 0;
            free_cnt[r]  = 0;
            for (int p = 0; p < PROCESSES; p++)
            begin
                claim_cnt[p][r] = 0;
                held_cnt[p][r]  = 0;
            end
        end
        no_gaps     = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clear_tables();
        test_directed();
        test_random();
        if (mismatches == 0 && answer_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bkr_pkg.sv
hw/rtl/bkr_if.sv
hw/rtl/bkr_ram.sv
hw/rtl/bankers_resource_manager_unit.sv
tb/sv/tb_bankers_resource_manager_unit.sv
